>>> rtl/tse_pkg.sv
// ----------------------------------------------------------------------------
// tse_pkg: shared types and constants for the Taylor series exp evaluator
//
// Holds the item structs of both channels, the sequencer state type and the
// fixed widths of the fixed-point datapath.
// ----------------------------------------------------------------------------
package tse_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_TERMS = 255;
    localparam int DEF_FRAC_BITS = 24;

    // Fixed field widths.
    localparam int COUNT_W = 8;
    localparam int X_W     = 32;
    localparam int SUM_W   = 64;

    // Full magnitude product of a 64-bit term and a 32-bit argument.
    localparam int PROD_W  = SUM_W + X_W;

    // Quotient bits the divider retires per cycle.
    localparam int DIV_RADIX_BITS = 8;

    // Input item.
    typedef struct packed {
        logic [COUNT_W-1:0]      term_count;
        logic signed [X_W-1:0]   x_value;
    } tse_in_t;

    // Result item.
    typedef struct packed {
        logic signed [SUM_W-1:0] series_sum;
        logic                    overflow;
    } tse_out_t;

    // Sequencer states: one pass from ST_MUL_LO to ST_ADD builds one term.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_RND,
        ST_DIV,
        ST_SAT,
        ST_NEG,
        ST_ADD,
        ST_FINISH
    } tse_state_t;

endpackage

>>> rtl/tse_divider.sv
// ----------------------------------------------------------------------------
// tse_divider: iterative unsigned divider by a small divisor
//
// Long division that retires DIV_RADIX_BITS quotient bits per cycle. A start
// pulse loads the dividend and divisor; done pulses in the cycle after the last
// step, with the quotient held on quotient until the next start.
// ----------------------------------------------------------------------------
module tse_divider
    import tse_pkg::*;
#(
    parameter int DIVIDEND_W = 72,
    parameter int DIVISOR_W  = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEPS = DIVIDEND_W / DIV_RADIX_BITS;
    localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;

    // Control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    // One radix step: a short chain of narrow compare-and-subtract stages.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        trial     = '0;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            quo_next  = '0;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            for (int b = 0; b < DIV_RADIX_BITS; b++) begin
                trial    = {rem_next, dvd_next[DIVIDEND_W-1]};
                dvd_next = {dvd_next[DIVIDEND_W-2:0], 1'b0};
                if (trial >= {1'b0, dsr_reg}) begin
                    trial    = trial - {1'b0, dsr_reg};
                    quo_next = {quo_next[DIVIDEND_W-2:0], 1'b1};
                end else begin
                    quo_next = {quo_next[DIVIDEND_W-2:0], 1'b0};
                end
                rem_next = trial[DIVISOR_W-1:0];
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/taylor_exp_evaluator.sv
// ----------------------------------------------------------------------------
// taylor_exp_evaluator: truncated Taylor series of exp(x) in fixed point
//
// An input item carries a term count N and a signed argument x with
// FRAC_BITS fraction bits. The result item carries the saturated sum of the
// terms 0..N of the series of exp(x), and a flag that is set when any term
// or partial sum saturated. N above MAX_TERMS is clamped to MAX_TERMS.
// Each term is the previous one times x, shifted down by FRAC_BITS (floor),
// then divided by its index (truncated toward zero).
//
// Both channels use valid/ready. s_ready is high only while the sequencer
// is idle; one item is worked on at a time. Each term passes through the
// shared 32x32 multiplier (two passes) and the 8-bit-per-cycle divider,
// whose dividend is 96 - FRAC_BITS bits wide. The result sits in an output
// register: the next item is accepted while a result waits, and the
// sequencer only holds at its last step when the receiver still stalls an
// earlier result. Reset returns the sequencer to idle and drops m_valid;
// nothing else persists between items.
// ----------------------------------------------------------------------------
module taylor_exp_evaluator
    import tse_pkg::*;
#(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  tse_in_t  s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output tse_out_t m_item
);

    localparam int IDX_W     = $clog2(MAX_TERMS + 1);
    localparam int SH_W      = PROD_W - FRAC_BITS;
    localparam int DIV_STEPS = (SH_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int DIV_W     = DIV_STEPS * DIV_RADIX_BITS;
    localparam int HALF_W    = SUM_W / 2;

    localparam logic [SUM_W-1:0] ONE_FX  = SUM_W'(1) << FRAC_BITS;
    localparam logic [SUM_W-1:0] POS_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] NEG_MAG = {1'b1, {(SUM_W-1){1'b0}}};

    tse_state_t state_reg, state_next;

    logic             x_neg_reg, x_neg_next;
    logic [X_W-1:0]   x_mag_reg, x_mag_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [SUM_W-1:0] term_mag_reg, term_mag_next;
    logic             term_neg_reg, term_neg_next;
    logic [SUM_W-1:0] term_val_reg, term_val_next;
    logic [SUM_W-1:0] qmag_reg, qmag_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             ovf_reg, ovf_next;
    logic [SUM_W-1:0] prod_lo_reg, prod_lo_next;
    logic [SUM_W-1:0] prod_hi_reg, prod_hi_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic             m_valid_reg, m_valid_next;
    tse_out_t         out_reg, out_next;

    // Sequencer outputs.
    logic             accept;
    logic             mul_hi_sel;
    logic             div_start;
    logic             out_load;

    // Shared datapath signals.
    logic [HALF_W-1:0] mul_a;
    logic [SUM_W-1:0]  mul_p;
    logic              res_neg;
    logic              rnd_up;
    logic [SH_W-1:0]   rounded;
    logic              div_done;
    logic [DIV_W-1:0]  quotient;
    logic [SUM_W-1:0]  limit;
    logic              term_sat;
    logic [SUM_W-1:0]  add_raw;
    logic              add_sat;
    logic [X_W-1:0]    x_raw;

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        x_neg_reg    <= x_neg_next;
        x_mag_reg    <= x_mag_next;
        n_reg        <= n_next;
        idx_reg      <= idx_next;
        term_mag_reg <= term_mag_next;
        term_neg_reg <= term_neg_next;
        term_val_reg <= term_val_next;
        qmag_reg     <= qmag_next;
        sum_reg      <= sum_next;
        ovf_reg      <= ovf_next;
        prod_lo_reg  <= prod_lo_next;
        prod_hi_reg  <= prod_hi_next;
        prod_reg     <= prod_next;
        out_reg      <= out_next;
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (32'(s_item.term_count) == 32'd0) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_MUL_LO;
                    end
                end
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_ACC;
            ST_ACC:    state_next = ST_RND;
            ST_RND:    state_next = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:    state_next = ST_NEG;
            ST_NEG:    state_next = ST_ADD;
            ST_ADD: begin
                if (idx_reg == n_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_MUL_LO;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_ready    = 1'b0;
        mul_hi_sel = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:   s_ready    = 1'b1;
            ST_MUL_HI: mul_hi_sel = 1'b1;
            ST_RND:    div_start  = 1'b1;
            ST_FINISH: out_load   = !m_valid_reg || m_ready;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    // Shared 32x32 multiplier, fed one half of the term magnitude per pass.
    assign mul_a = mul_hi_sel ? term_mag_reg[SUM_W-1:HALF_W] : term_mag_reg[HALF_W-1:0];
    assign mul_p = {{(SUM_W-HALF_W){1'b0}}, mul_a} * {{(SUM_W-X_W){1'b0}}, x_mag_reg};

    // Sign of the new term, and the shift of the magnitude that floors the signed value.
    assign res_neg = term_neg_reg ^ x_neg_reg;
    assign rnd_up  = res_neg && (prod_reg[FRAC_BITS-1:0] != '0);
    assign rounded = SH_W'(prod_reg >> FRAC_BITS) + SH_W'(rnd_up);

    tse_divider #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (IDX_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (DIV_W'(rounded)),
        .divisor  (idx_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Term saturation bound and the saturating sum.
    assign limit    = res_neg ? NEG_MAG : POS_MAX;
    assign term_sat = (quotient > DIV_W'(limit));
    assign add_raw  = sum_reg + term_val_reg;
    assign add_sat  = (sum_reg[SUM_W-1] == term_val_reg[SUM_W-1]) &&
                      (add_raw[SUM_W-1] != sum_reg[SUM_W-1]);
    assign x_raw    = s_item.x_value;

    // Datapath next values.
    always_comb begin
        x_neg_next    = x_neg_reg;
        x_mag_next    = x_mag_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        term_mag_next = term_mag_reg;
        term_neg_next = term_neg_reg;
        term_val_next = term_val_reg;
        qmag_next     = qmag_reg;
        sum_next      = sum_reg;
        ovf_next      = ovf_reg;
        prod_lo_next  = prod_lo_reg;
        prod_hi_next  = prod_hi_reg;
        prod_next     = prod_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    x_neg_next = x_raw[X_W-1];
                    x_mag_next = x_raw[X_W-1] ? (~x_raw + X_W'(1)) : x_raw;
                    if (32'(s_item.term_count) > 32'(MAX_TERMS)) begin
                        n_next = IDX_W'(MAX_TERMS);
                    end else begin
                        n_next = IDX_W'(s_item.term_count);
                    end
                    idx_next      = IDX_W'(1);
                    term_mag_next = ONE_FX;
                    term_neg_next = 1'b0;
                    sum_next      = ONE_FX;
                    ovf_next      = 1'b0;
                end
            end
            ST_MUL_LO: prod_lo_next = mul_p;
            ST_MUL_HI: prod_hi_next = mul_p;
            ST_ACC: begin
                prod_next = {{(PROD_W-SUM_W){1'b0}}, prod_lo_reg} +
                            {prod_hi_reg, {(PROD_W-SUM_W){1'b0}}};
            end
            ST_SAT: begin
                if (term_sat) begin
                    qmag_next = limit;
                    ovf_next  = 1'b1;
                end else begin
                    qmag_next = quotient[SUM_W-1:0];
                end
            end
            ST_NEG: begin
                term_val_next = res_neg ? (~qmag_reg + SUM_W'(1)) : qmag_reg;
                term_mag_next = qmag_reg;
                term_neg_next = res_neg && (qmag_reg != '0);
            end
            ST_ADD: begin
                if (add_sat) begin
                    sum_next = sum_reg[SUM_W-1] ? NEG_MAG : POS_MAX;
                    ovf_next = 1'b1;
                end else begin
                    sum_next = add_raw;
                end
                if (idx_reg != n_reg) begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            default: begin
                prod_next = prod_reg;
            end
        endcase
    end

    // Output register: loaded at the end of an item, held while stalled.
    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (out_load) begin
            out_next.series_sum = sum_reg;
            out_next.overflow   = ovf_reg;
            m_valid_next        = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

endmodule
